// ----- src/spmv_pkg.sv -----
// Shared constants and types for the CSR sparse matrix-vector multiply block.
`default_nettype none

package spmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);

    localparam int INDEX_W      = 10;
    localparam int DATA_W       = 32;
    localparam int SUM_W        = 64;
    localparam int LEN_W        = 11;
    localparam int CMD_W        = 2;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int CNT_W        = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;

    localparam logic REG_VECTOR_LENGTH = 1'b0;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 11'd1024;

    localparam logic [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [INDEX_W-1:0]      index_t;

endpackage

`default_nettype wire

// ----- src/spmv_if.sv -----
// Handshake channels for command items and row sum items.
`default_nettype none

interface spmv_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [spmv_pkg::CMD_W-1:0]        cmd;
    spmv_pkg::index_t                  index;
    logic signed [spmv_pkg::DATA_W-1:0] data_value;
    logic                              row_last;

    modport source (output valid, cmd, index, data_value, row_last, input ready);
    modport sink (input valid, cmd, index, data_value, row_last, output ready);
endinterface

interface spmv_sum_if;
    logic              valid;
    logic              ready;
    spmv_pkg::sum_t    row_sum;
    spmv_pkg::index_t  row_number;
    logic              last_row;
    logic              saturated;
    logic              bad_column;

    modport source (output valid, row_sum, row_number, last_row, saturated, bad_column,
                    input ready);
    modport sink (input valid, row_sum, row_number, last_row, saturated, bad_column,
                  output ready);
endinterface

`default_nettype wire

// ----- src/csr_sparse_matrix_vector_multiply.sv -----
// Top level of the CSR sparse matrix-vector multiply block.
//
// The block takes one command item per clock cycle. A load item writes one
// entry of the dense vector store; nonzero items read the store and, for a
// column inside the vector length, multiply and accumulate into the running
// row sum; a row-last nonzero or a close item produces one row sum item. The
// synchronous store read is registered when the item that closes the row is
// accepted; then the product is registered, and then the saturating sum is
// loaded into the output register. The single store read port and the one
// multiply-accumulate unit set the rate of one item per cycle; input is held
// off only while a closed row waits behind a row sum item that has not yet
// been taken.
`default_nettype none

module csr_sparse_matrix_vector_multiply
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    spmv_cmd_if.sink                           cmds,
    spmv_sum_if.source                         sums,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spmv_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [spmv_pkg::PDATA_W-1:0]  pwdata,
    output logic      [spmv_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    logic [spmv_pkg::LEN_W-1:0] vector_length_reg;
    logic [spmv_pkg::CNT_W-1:0] eff_len;
    logic                       cfg_write;

    logic                       hold;
    logic                       adv;
    logic                       fire;
    logic                       is_load;
    logic                       is_nonzero;
    logic                       is_close;
    logic                       col_ok;
    logic                       load_ok;

    logic [spmv_pkg::VALUE_WIDTH-1:0]        vector_store [spmv_pkg::VECTOR_DEPTH];
    logic signed [spmv_pkg::VALUE_WIDTH-1:0] rd_data_reg;

    logic                                    s1_valid_reg;
    logic                                    s1_acc_reg;
    logic                                    s1_bad_reg;
    logic                                    s1_emit_reg;
    logic signed [spmv_pkg::VALUE_WIDTH-1:0] s1_value_reg;

    logic signed [2*spmv_pkg::VALUE_WIDTH-1:0] prod_full;

    logic            s2_valid_reg;
    logic            s2_acc_reg;
    logic            s2_bad_reg;
    logic            s2_emit_reg;
    spmv_pkg::sum_t  s2_prod_reg;

    spmv_pkg::sum_t    running_sum_reg;
    spmv_pkg::sum_t    running_sum_next;
    spmv_pkg::sum_t    addend;
    spmv_pkg::sum_t    raw_sum;
    logic              overflow;
    logic              sum_saturated_reg;
    logic              sum_saturated_next;
    logic              column_error_reg;
    logic              column_error_next;
    spmv_pkg::index_t  row_counter_reg;
    logic              is_last;
    logic              commit;
    logic              commit_emit;

    logic              out_valid_reg;
    spmv_pkg::sum_t    out_sum_reg;
    spmv_pkg::index_t  out_row_reg;
    logic              out_last_reg;
    logic              out_sat_reg;
    logic              out_bad_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[spmv_pkg::PADDR_W-1] == spmv_pkg::REG_VECTOR_LENGTH);

    always_comb
    begin
        prdata = '0;
        if (paddr[spmv_pkg::PADDR_W-1] == spmv_pkg::REG_VECTOR_LENGTH)
        begin
            prdata = spmv_pkg::PDATA_W'(vector_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= spmv_pkg::LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            vector_length_reg <= pwdata[spmv_pkg::LEN_W-1:0];
        end
    end

    assign eff_len = (spmv_pkg::CNT_W'(vector_length_reg) > spmv_pkg::CNT_W'(spmv_pkg::VECTOR_DEPTH))
                     ? spmv_pkg::CNT_W'(spmv_pkg::VECTOR_DEPTH)
                     : spmv_pkg::CNT_W'(vector_length_reg);

    // Input decode. The pipeline stalls only when a closed row cannot leave.
    assign hold       = out_valid_reg && !sums.ready && s2_valid_reg && s2_emit_reg;
    assign adv        = !hold;
    assign cmds.ready = adv;
    assign fire       = cmds.valid && adv;
    assign is_load    = (cmds.cmd == spmv_pkg::CMD_LOAD);
    assign is_nonzero = (cmds.cmd == spmv_pkg::CMD_NONZERO);
    assign is_close   = (cmds.cmd == spmv_pkg::CMD_CLOSE);
    assign col_ok     = spmv_pkg::CNT_W'(cmds.index) < eff_len;
    assign load_ok    = spmv_pkg::CNT_W'(cmds.index) < spmv_pkg::CNT_W'(spmv_pkg::VECTOR_DEPTH);

    // Vector store: one write and, unless the pipeline stalls, one registered read per cycle. A load is
    // written at its accept edge, so any later nonzero reads the new entry.
    always_ff @(posedge clk)
    begin
        if (fire && is_load && load_ok)
        begin
            vector_store[spmv_pkg::ADDR_W'(cmds.index)] <=
                cmds.data_value[spmv_pkg::VALUE_WIDTH-1:0];
        end
        if (adv)
        begin
            rd_data_reg <= vector_store[spmv_pkg::ADDR_W'(cmds.index)];
        end
    end

    // Stage one: item fields alongside the store read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= fire && (is_nonzero || is_close);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_acc_reg   <= is_nonzero && col_ok;
            s1_bad_reg   <= is_nonzero && !col_ok;
            s1_emit_reg  <= is_close || (is_nonzero && cmds.row_last);
            s1_value_reg <= cmds.data_value[spmv_pkg::VALUE_WIDTH-1:0];
        end
    end

    // Stage two: product register.
    assign prod_full = s1_value_reg * rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_acc_reg  <= s1_acc_reg;
            s2_bad_reg  <= s1_bad_reg;
            s2_emit_reg <= s1_emit_reg;
            s2_prod_reg <= spmv_pkg::SUM_W'(prod_full);
        end
    end

    // Saturating accumulate and row bookkeeping.
    always_comb
    begin
        addend   = s2_acc_reg ? s2_prod_reg : '0;
        raw_sum  = running_sum_reg + addend;
        overflow = (running_sum_reg[spmv_pkg::SUM_W-1] == addend[spmv_pkg::SUM_W-1])
                   && (raw_sum[spmv_pkg::SUM_W-1] != running_sum_reg[spmv_pkg::SUM_W-1]);
        if (overflow)
        begin
            running_sum_next = running_sum_reg[spmv_pkg::SUM_W-1]
                               ? spmv_pkg::SUM_MIN : spmv_pkg::SUM_MAX;
        end
        else
        begin
            running_sum_next = raw_sum;
        end
        sum_saturated_next = sum_saturated_reg || overflow;
        column_error_next  = column_error_reg || s2_bad_reg;
    end

    assign is_last     = (eff_len != '0)
                         && (spmv_pkg::CNT_W'(row_counter_reg) == (eff_len - spmv_pkg::CNT_W'(1)));
    assign commit      = s2_valid_reg && adv;
    assign commit_emit = commit && s2_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= '0;
            sum_saturated_reg <= 1'b0;
            column_error_reg  <= 1'b0;
            row_counter_reg   <= '0;
        end
        else if (commit)
        begin
            if (s2_emit_reg)
            begin
                running_sum_reg   <= '0;
                sum_saturated_reg <= 1'b0;
                column_error_reg  <= 1'b0;
                row_counter_reg   <= is_last ? '0 : row_counter_reg + 1'b1;
            end
            else
            begin
                running_sum_reg   <= running_sum_next;
                sum_saturated_reg <= sum_saturated_next;
                column_error_reg  <= column_error_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sums.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_emit)
        begin
            out_sum_reg  <= running_sum_next;
            out_row_reg  <= row_counter_reg;
            out_last_reg <= is_last;
            out_sat_reg  <= sum_saturated_next;
            out_bad_reg  <= column_error_next;
        end
    end

    assign sums.valid      = out_valid_reg;
    assign sums.row_sum    = out_sum_reg;
    assign sums.row_number = out_row_reg;
    assign sums.last_row   = out_last_reg;
    assign sums.saturated  = out_sat_reg;
    assign sums.bad_column = out_bad_reg;

    // A closed row always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit_emit |=> out_valid_reg)
        else $error("closed row did not reach the output register");

    // Closing a row starts the next one from a clean sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit_emit |=> (running_sum_reg == '0) && !sum_saturated_reg && !column_error_reg)
        else $error("row state not cleared after a row sum item");

    // The last row wraps the row counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit_emit && is_last |=> (row_counter_reg == '0))
        else $error("row counter did not wrap after the last row");

    // Input is held off only while a closed row waits on a full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmds.ready |-> out_valid_reg && s2_valid_reg && s2_emit_reg)
        else $error("input stalled without a blocked row sum item");

endmodule

`default_nettype wire

// ----- tb/spmv_row_sum_checker.sv -----
// Checker that mirrors the sparse matrix-vector block and compares every row sum item.
module spmv_row_sum_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    spmv_cmd_if                                 cmds,
    spmv_sum_if                                 sums,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spmv_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [spmv_pkg::PDATA_W-1:0]   pwdata,
    input  wire logic                           pready,
    output int unsigned                         mismatches,
    output int unsigned                         rows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        spmv_pkg::sum_t   row_sum;
        spmv_pkg::index_t row_number;
        logic             last_row;
        logic             saturated;
        logic             bad_column;
    } row_result_t;

    localparam logic [spmv_pkg::PADDR_W-1:0] LENGTH_ADDR =
        spmv_pkg::PADDR_W'(4 * spmv_pkg::REG_VECTOR_LENGTH);

    logic [spmv_pkg::DATA_W-1:0] shadow_vector [spmv_pkg::VECTOR_DEPTH];
    logic [spmv_pkg::LEN_W-1:0]  length_setting;
    spmv_pkg::sum_t              partial_sum;
    spmv_pkg::index_t            current_row;
    logic                        sum_clipped;
    logic                        column_missed;
    int unsigned                 error_total;
    row_result_t                 pending_row_sums [$];

    function automatic int unsigned rows_in_use();
        return (length_setting > spmv_pkg::VECTOR_DEPTH) ? spmv_pkg::VECTOR_DEPTH
                                                          : length_setting;
    endfunction

    task automatic close_row();
        row_result_t res;
        int unsigned span;
        span = rows_in_use();
        res.row_sum    = partial_sum;
        res.row_number = current_row;
        res.last_row   = (span != 0) && (current_row == span - 1);
        res.saturated  = sum_clipped;
        res.bad_column = column_missed;
        pending_row_sums.push_back(res);
        partial_sum   = '0;
        sum_clipped   = 1'b0;
        column_missed = 1'b0;
        current_row   = res.last_row ? '0 : current_row + 1'b1;
    endtask

    task automatic check_field(input string name, input logic [spmv_pkg::SUM_W-1:0] want,
                               input logic [spmv_pkg::SUM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        row_result_t    want;
        spmv_pkg::sum_t factor_a;
        spmv_pkg::sum_t factor_b;
        spmv_pkg::sum_t product;
        spmv_pkg::sum_t total;
        if (!rst_n)
        begin
            length_setting = spmv_pkg::LENGTH_RESET;
            partial_sum    = '0;
            current_row    = '0;
            sum_clipped    = 1'b0;
            column_missed  = 1'b0;
            error_total    = 0;
            pending_row_sums.delete();
            mismatches   <= 0;
            rows_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LENGTH_ADDR)
                length_setting = pwdata[spmv_pkg::LEN_W-1:0];
            if (sums.valid && sums.ready)
            begin
                if (pending_row_sums.size() == 0)
                begin
                    $display("%0t: unexpected row sum %0h for row %0d", $time,
                             sums.row_sum, sums.row_number);
                    error_total++;
                end
                else
                begin
                    want = pending_row_sums.pop_front();
                    check_field("row_sum", want.row_sum, sums.row_sum);
                    check_field("row_number", want.row_number, sums.row_number);
                    check_field("last_row", want.last_row, sums.last_row);
                    check_field("saturated", want.saturated, sums.saturated);
                    check_field("bad_column", want.bad_column, sums.bad_column);
                end
            end
            if (cmds.valid && cmds.ready)
            begin
                case (cmds.cmd)
                    spmv_pkg::CMD_LOAD:
                        shadow_vector[cmds.index] = cmds.data_value;
                    spmv_pkg::CMD_NONZERO:
                    begin
                        if (cmds.index < rows_in_use())
                        begin
                            factor_a = spmv_pkg::sum_t'(cmds.data_value);
                            factor_b = spmv_pkg::sum_t'($signed(shadow_vector[cmds.index]));
                            product  = factor_a * factor_b;
                            total    = partial_sum + product;
                            if (partial_sum[spmv_pkg::SUM_W-1] == product[spmv_pkg::SUM_W-1]
                                && total[spmv_pkg::SUM_W-1] != partial_sum[spmv_pkg::SUM_W-1])
                            begin
                                total       = partial_sum[spmv_pkg::SUM_W-1]
                                              ? spmv_pkg::SUM_MIN : spmv_pkg::SUM_MAX;
                                sum_clipped = 1'b1;
                            end
                            partial_sum = total;
                        end
                        else
                            column_missed = 1'b1;
                        if (cmds.row_last)
                            close_row();
                    end
                    spmv_pkg::CMD_CLOSE:
                        close_row();
                    default:
                        ;
                endcase
            end
            mismatches   <= error_total;
            rows_pending <= pending_row_sums.size();
        end
    end

endmodule

// ----- tb/csr_sparse_matrix_vector_multiply_tb.sv -----
// Top of the testbench: clock, reset, register writes and command item stimulus.
module csr_sparse_matrix_vector_multiply_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int unsigned { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    localparam logic [spmv_pkg::CMD_W-1:0]   CMD_UNUSED        = 2'd3;
    localparam logic [spmv_pkg::PADDR_W-1:0] LENGTH_ADDR       =
        spmv_pkg::PADDR_W'(4 * spmv_pkg::REG_VECTOR_LENGTH);
    localparam int                           CYCLE_LIMIT       = 400000;
    localparam int                           SETTLE_CYCLES     = 8;
    localparam int                           ACTIONS_PER_PHASE = 18;
    localparam int                           HEAVY_PCT         = 46;
    localparam int                           LIGHT_PCT         = 6;
    localparam logic [spmv_pkg::LEN_W-1:0]   WRAP_LENGTH       = 11'd8;
    localparam int                           PHASE_COUNT       = 9;
    localparam logic [spmv_pkg::LEN_W-1:0]   PHASE_LENGTHS [PHASE_COUNT] =
        '{11'd1, 11'd3, 11'd8, 11'd16, 11'd64, 11'd1024, 11'd1025, 11'd2047, 11'd0};

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [spmv_pkg::PADDR_W-1:0] paddr;
    logic [spmv_pkg::PDATA_W-1:0] pwdata;
    logic [spmv_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      cycle_count    = 0;
    int unsigned      rows_closed    = 0;
    int unsigned      mismatches;
    int unsigned      rows_pending;
    bit               loaded [spmv_pkg::VECTOR_DEPTH];
    spmv_pkg::index_t loaded_list [$];

    spmv_cmd_if cmd_ch ();
    spmv_sum_if sum_ch ();

    csr_sparse_matrix_vector_multiply dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmds    (cmd_ch),
        .sums    (sum_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spmv_row_sum_checker row_sums_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmds         (cmd_ch),
        .sums         (sum_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .rows_pending (rows_pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL csr_sparse_matrix_vector_multiply");
            $finish;
        end
    end

    always @(posedge clk)
        sum_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? HEAVY_PCT : (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? HEAVY_PCT
                       : (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
    endtask

    task automatic send_item(input logic [spmv_pkg::CMD_W-1:0] code,
                             input spmv_pkg::index_t idx,
                             input logic [spmv_pkg::DATA_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= code;
        cmd_ch.index      <= idx;
        cmd_ch.data_value <= value;
        cmd_ch.row_last   <= last;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (code == spmv_pkg::CMD_LOAD && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        if (code == spmv_pkg::CMD_CLOSE || (code == spmv_pkg::CMD_NONZERO && last))
            rows_closed++;
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [spmv_pkg::LEN_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LENGTH_ADDR;
        pwdata  <= spmv_pkg::PDATA_W'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [spmv_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(32'h0001_FFFF) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // Columns inside the active length are always entries that were loaded.
    function automatic spmv_pkg::index_t pick_column(input int unsigned span);
        if (span == 0 || (span < spmv_pkg::VECTOR_DEPTH && $urandom_range(99) < 8))
            return spmv_pkg::index_t'($urandom_range(spmv_pkg::VECTOR_DEPTH - 1, span));
        if (span < spmv_pkg::VECTOR_DEPTH)
            return spmv_pkg::index_t'($urandom_range(span - 1));
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    initial
    begin : stimulus
        int unsigned span;
        int unsigned nz;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.cmd        <= spmv_pkg::CMD_LOAD;
        cmd_ch.index      <= '0;
        cmd_ch.data_value <= '0;
        cmd_ch.row_last   <= 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_NONE);
        send_item(spmv_pkg::CMD_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(spmv_pkg::CMD_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
        send_item(spmv_pkg::CMD_LOAD, 10'd1, 32'h0001_0000, 1'b0);
        send_item(spmv_pkg::CMD_LOAD, 10'd2, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_item(spmv_pkg::CMD_CLOSE, 10'd0, 32'h0000_0000, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b1);
        send_item(spmv_pkg::CMD_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd0, 32'h8000_0000, 1'b1);
        send_item(spmv_pkg::CMD_NONZERO, 10'd1, 32'h0001_0000, 1'b0);
        send_item(spmv_pkg::CMD_LOAD, 10'd1, 32'h0002_0000, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd1, 32'hFFFF_0000, 1'b1);
        send_item(spmv_pkg::CMD_NONZERO, 10'd2, 32'hFFFF_FFFF, 1'b0);
        send_item(spmv_pkg::CMD_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b1);
        send_item(spmv_pkg::CMD_CLOSE, 10'd1023, 32'hFFFF_FFFF, 1'b1);

        // Close rows at a short length until the row counter wraps back to zero.
        wait_idle();
        write_length(WRAP_LENGTH);
        set_idle(IDLE_RECEIVER);
        while (rows_closed < WRAP_LENGTH)
            send_item(spmv_pkg::CMD_CLOSE, 10'd0, 32'h0000_0000, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            write_length(PHASE_LENGTHS[p]);
            set_idle(idle_mode_t'(p % 4));
            span = (PHASE_LENGTHS[p] > spmv_pkg::VECTOR_DEPTH) ? spmv_pkg::VECTOR_DEPTH
                                                               : PHASE_LENGTHS[p];
            if (span < spmv_pkg::VECTOR_DEPTH)
            begin
                for (int i = 0; i < span; i++)
                    send_item(spmv_pkg::CMD_LOAD, spmv_pkg::index_t'(i), pick_value(),
                              1'($urandom_range(1)));
            end
            else
            begin
                repeat (24)
                    send_item(spmv_pkg::CMD_LOAD,
                              spmv_pkg::index_t'($urandom_range(spmv_pkg::VECTOR_DEPTH - 1)),
                              pick_value(), 1'($urandom_range(1)));
            end
            repeat (ACTIONS_PER_PHASE)
            begin
                case ($urandom_range(19))
                    0:
                        send_item(CMD_UNUSED, spmv_pkg::index_t'($urandom), $urandom,
                                  1'($urandom_range(1)));
                    1, 2:
                        send_item(spmv_pkg::CMD_LOAD,
                                  spmv_pkg::index_t'($urandom_range(spmv_pkg::VECTOR_DEPTH - 1)),
                                  pick_value(), 1'($urandom_range(1)));
                    3:
                        send_item(spmv_pkg::CMD_CLOSE, spmv_pkg::index_t'($urandom), $urandom,
                                  1'($urandom_range(1)));
                    4:
                    begin
                        nz = $urandom_range(1, 4);
                        repeat (nz)
                            send_item(spmv_pkg::CMD_NONZERO, pick_column(span), pick_value(),
                                      1'b0);
                        send_item(spmv_pkg::CMD_CLOSE, spmv_pkg::index_t'($urandom), $urandom,
                                  1'b0);
                    end
                    default:
                    begin
                        nz = $urandom_range(1, 4);
                        for (int k = 1; k <= nz; k++)
                            send_item(spmv_pkg::CMD_NONZERO, pick_column(span), pick_value(),
                                      k == nz);
                    end
                endcase
            end
        end

        wait_idle();
        if (mismatches == 0 && rows_pending == 0)
            $display("PASS csr_sparse_matrix_vector_multiply");
        else
            $display("FAIL csr_sparse_matrix_vector_multiply");
        $finish;
    end

endmodule
